@@ hw/rtl/roulette_wheel_selector_macros.svh @@
// Assertion macros for the roulette wheel selector checker.
// Depends on nothing; the asserting file provides clk and rst in scope.
`ifndef ROULETTE_WHEEL_SELECTOR_MACROS_SVH
`define ROULETTE_WHEEL_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define RWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define RWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rws_pkg.sv @@
// Shared constants, codes and types of the roulette wheel selector.
// Depends on nothing; imported by every module of the block except rws_ram.
package rws_pkg;

  // Capacity of the member set
  localparam int MAX_MEMBERS = 128;

  // Port field widths
  localparam int OP_W      = 2;
  localparam int FIT_W     = 32;
  localparam int FRAC_W    = 17;
  localparam int OUT_IDX_W = 7;
  localparam int STATUS_W  = 2;

  // Fraction bits of the fixed-point formats
  localparam int FRAC_BITS = 16;

  // Derived storage widths
  localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int CW    = FIT_W + IDX_W;   // cumulative sum, never overflows
  localparam int PW    = CW + FRAC_W;     // r * total

  // Operation codes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SELECT = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Launch of a search
  typedef struct packed {
    logic              launch;
    logic [FRAC_W-1:0] r;
    logic [CW-1:0]     total;
    logic [IDX_W-1:0]  last;
  } srch_cmd_t;

  // Outcome of a search
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] index;
  } srch_res_t;

endpackage

@@ hw/rtl/rws_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module rws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/rws_search.sv @@
// Binary search over the cumulative-sum store, one RAM read per step.
// Depends on rws_pkg; drives the read port of the store.
module rws_search (
  input  logic                      clk,
  input  logic                      rst,
  input  rws_pkg::srch_cmd_t        cmd,
  input  logic [rws_pkg::CW-1:0]    rdata,
  output logic [rws_pkg::IDX_W-1:0] raddr,
  output rws_pkg::srch_res_t        res
);

  import rws_pkg::*;

  logic             active;
  logic [PW-1:0]    target;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic [IDX_W-1:0] mid;
  logic             done;
  logic [IDX_W-1:0] index;

  logic [PW-1:0]    prod;
  logic [PW-1:0]    scaled;
  logic             reached;
  logic [IDX_W-1:0] lo_next;
  logic [IDX_W-1:0] hi_next;
  logic [IDX_W-1:0] mid_next;

  // Threshold r * total
  assign prod = cmd.r * cmd.total;

  // Compare the entry just read against the threshold and narrow the range
  assign scaled   = {1'b0, rdata, {FRAC_BITS{1'b0}}};
  assign reached  = (scaled >= target);
  assign lo_next  = reached ? lo : mid + IDX_W'(1);
  assign hi_next  = reached ? mid : hi;
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);

  // Launch reads the middle of the full range, a step reads the next middle
  assign raddr = cmd.launch ? (cmd.last >> 1) : mid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.launch) begin
        if (cmd.last == '0) begin
          done <= 1'b1;
        end else begin
          active <= 1'b1;
        end
      end else if (active) begin
        if (lo_next >= hi_next) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Hold the search range and the result index
  always_ff @(posedge clk) begin
    if (cmd.launch) begin
      target <= prod;
      lo     <= '0;
      hi     <= cmd.last;
      mid    <= cmd.last >> 1;
      index  <= '0;
    end else if (active) begin
      lo    <= lo_next;
      hi    <= hi_next;
      mid   <= mid_next;
      index <= lo_next;
    end
  end

  assign res.done  = done;
  assign res.index = index;

endmodule

@@ hw/rtl/roulette_wheel_selector.sv @@
// Top level of the roulette wheel selector: command decode, running total
// and member count. Depends on rws_pkg, rws_ram and rws_search.
//
// Usage:
//   A command beat is taken at a rising edge with start high and busy low:
//   op, fitness and random_fraction are sampled there. Every command gives
//   exactly one result beat: done is high for one cycle with chosen_index
//   and status valid; the receiver cannot hold it off.
//   Loads, unused codes and selects on an empty set or a zero total end in
//   the execute state, from which done is registered; the next command can
//   be taken once done is high.
//   Select: one store read per binary search step, at most s = ceil(log2(n))
//   steps for n members (exactly 7 at 128). The search reads one store entry
//   per cycle, and done is registered from the wait state once it ends.
//   busy drops in the cycle in which done is high, so the next command may
//   be taken while a result is shown.
//   Reset clears the set (no members, total zero) and idles the block; no
//   clearing pass runs, since only written entries are ever read.
module roulette_wheel_selector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rws_pkg::OP_W-1:0]      op,
  input  logic [rws_pkg::FIT_W-1:0]     fitness,
  input  logic [rws_pkg::FRAC_W-1:0]    random_fraction,
  output logic                          done,
  output logic [rws_pkg::OUT_IDX_W-1:0] chosen_index,
  output logic [rws_pkg::STATUS_W-1:0]  status
);

  import rws_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [OP_W-1:0]   op_q;
  logic [FIT_W-1:0]  fit_q;
  logic [FRAC_W-1:0] r_q;
  logic [CW-1:0]     total;
  logic [CW-1:0]     total_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic                 fin;
  logic [STATUS_W-1:0]  fin_status;
  logic [OUT_IDX_W-1:0] fin_index;

  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [CW-1:0]    wdata;
  logic [IDX_W-1:0] raddr;
  logic [CW-1:0]    rdata;

  srch_cmd_t cmd;
  srch_res_t res;

  logic accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Decode the command and work out the next state of the set
  always_comb begin
    state_next = state;
    total_next = total;
    count_next = count;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_index  = '0;
    we         = 1'b0;
    waddr      = '0;
    wdata      = total + CW'(fit_q);
    cmd.launch = 1'b0;
    cmd.r      = r_q;
    cmd.total  = total;
    cmd.last   = IDX_W'(count - CNT_W'(1));
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        fin        = 1'b1;
        case (op_q)
          OP_START: begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = CW'(fit_q);
            total_next = CW'(fit_q);
            count_next = CNT_W'(1);
          end
          OP_APPEND: begin
            if (count == CNT_W'(MAX_MEMBERS)) begin
              fin_status = ST_FULL;
            end else begin
              we         = 1'b1;
              waddr      = IDX_W'(count);
              total_next = wdata;
              count_next = count + CNT_W'(1);
            end
          end
          OP_SELECT: begin
            if (count == '0) begin
              fin_status = ST_EMPTY;
            end else if (total != '0) begin
              cmd.launch = 1'b1;
              fin        = 1'b0;
              state_next = S_WAIT;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      S_WAIT: begin
        if (res.done) begin
          fin        = 1'b1;
          fin_index  = OUT_IDX_W'(res.index);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance the control state and the set summary
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      total <= total_next;
      count <= count_next;
      done  <= fin;
    end
  end

  // Capture the command beat and the result beat
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op;
      fit_q <= fitness;
      r_q   <= random_fraction;
    end
    if (fin) begin
      chosen_index <= fin_index;
      status       <= fin_status;
    end
  end

  rws_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_MEMBERS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  rws_search u_search (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rdata (rdata),
    .raddr (raddr),
    .res   (res)
  );

endmodule

@@ hw/rtl/rws_checker.sv @@
// Port-level checker for the roulette wheel selector, bound to the top level.
// Depends on rws_pkg and roulette_wheel_selector_macros.svh.
`include "roulette_wheel_selector_macros.svh"

module rws_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [rws_pkg::OP_W-1:0]      op,
  input logic                          done,
  input logic [rws_pkg::OUT_IDX_W-1:0] chosen_index,
  input logic [rws_pkg::STATUS_W-1:0]  status
);

  import rws_pkg::*;

  // An accepted beat occupies the block
  `RWS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")

  // The block is free again whenever a result beat is shown
  `RWS_ASSERT_IMP(a_done_free, done, !busy, "result shown while still busy")

  // Failed commands report index zero
  `RWS_ASSERT_IMP(a_fail_index, done && status != ST_OK, chosen_index == '0, "index on failure")

  // An accepted start command always gives a result beat with status OK
  `RWS_ASSERT_NXT(a_start_ok, start && !busy && op == OP_START, ##1 (done && status == ST_OK), "start result missing")

  // busy rises only on an accepted beat
  `RWS_ASSERT_IMP(a_busy_cause, $rose(busy), $past(start), "busy rose without a command")

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .op           (op),
  .done         (done),
  .chosen_index (chosen_index),
  .status       (status)
);

@@ tb/sv/tb_roulette_wheel_selector.sv @@
// Self-checking testbench for roulette_wheel_selector: directed and random command beats.
// Depends on rws_pkg and the roulette_wheel_selector RTL; predicts every result in-line.
// Drives beats from a command queue and checks each result beat in order.
module tb_roulette_wheel_selector;
  timeunit 1ns;
  timeprecision 1ps;

  import rws_pkg::*;

  // Op code that the block leaves unused
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

  typedef struct {
    logic [OP_W-1:0]   code;
    logic [FIT_W-1:0]  fit;
    logic [FRAC_W-1:0] frac;
  } command_t;

  typedef struct {
    logic [OUT_IDX_W-1:0] index;
    logic [STATUS_W-1:0]  status;
  } pick_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [OP_W-1:0] op = OP_START;
  logic [FIT_W-1:0] fitness = '0;
  logic [FRAC_W-1:0] random_fraction = '0;
  logic busy;
  logic done;
  logic [OUT_IDX_W-1:0] chosen_index;
  logic [STATUS_W-1:0] status;

  command_t pending_cmds[$];
  pick_t expected_picks[$];
  int sender_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  // Shadow of the selector state
  logic [CW-1:0] shadow_cum[MAX_MEMBERS];
  logic [CW-1:0] shadow_total = '0;
  int shadow_count = 0;

  roulette_wheel_selector uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .fitness(fitness),
    .random_fraction(random_fraction),
    .done(done),
    .chosen_index(chosen_index),
    .status(status)
  );

  always #6 clk = ~clk;

  function automatic void add_member(input logic [FIT_W-1:0] fit);
    shadow_total = shadow_total + CW'(fit);
    shadow_cum[shadow_count] = shadow_total;
    shadow_count++;
  endfunction

  // Work out the result of one command and advance the shadow state
  function automatic pick_t predict_pick(input logic [OP_W-1:0] code,
                                         input logic [FIT_W-1:0] fit,
                                         input logic [FRAC_W-1:0] frac);
    pick_t p;
    logic [63:0] target;
    int lo;
    int hi;
    int mid;
    p.index = '0;
    p.status = ST_OK;
    case (code)
      OP_START: begin
        shadow_count = 0;
        shadow_total = '0;
        add_member(fit);
      end
      OP_APPEND: begin
        if (shadow_count >= MAX_MEMBERS) p.status = ST_FULL;
        else add_member(fit);
      end
      OP_SELECT: begin
        if (shadow_count == 0) begin
          p.status = ST_EMPTY;
        end else if (shadow_total != '0) begin
          // first member whose scaled cumulative sum reaches r * total
          target = 64'(frac) * 64'(shadow_total);
          lo = 0;
          hi = shadow_count - 1;
          while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if ((64'(shadow_cum[mid]) << FRAC_BITS) >= target) hi = mid;
            else lo = mid + 1;
          end
          p.index = OUT_IDX_W'(lo);
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic queue_command(input logic [OP_W-1:0] code, input logic [FIT_W-1:0] fit,
                               input logic [FRAC_W-1:0] frac);
    command_t c;
    c.code = code;
    c.fit = fit;
    c.frac = frac;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Bias fitness towards zero, all ones and small values
  function automatic logic [FIT_W-1:0] rand_fitness();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return FIT_W'($urandom_range(0, 65535));
      3: return $urandom & 32'h00FF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Bias the fraction towards zero, one and values above one
  function automatic logic [FRAC_W-1:0] rand_fraction();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return FRAC_ONE;
      2: return FRAC_W'($urandom_range(65537, 131071));
      3: return FRAC_ONE - 1'b1;
      default: return FRAC_W'($urandom_range(0, 65536));
    endcase
  endfunction

  // Queue well-formed sets with random content, plus stray beats
  task automatic add_random(input int n, input bit with_fill);
    int added;
    int len;
    int roll;
    logic [OP_W-1:0] code;
    added = 0;
    if (with_fill) begin
      // grow to capacity with selects mixed in, then push past it
      queue_command(OP_START, rand_fitness(), rand_fraction());
      added++;
      repeat (MAX_MEMBERS + 2) begin
        queue_command(OP_APPEND, rand_fitness(), rand_fraction());
        added++;
        if ($urandom_range(0, 9) == 0) begin
          queue_command(OP_SELECT, rand_fitness(), rand_fraction());
          added++;
        end
      end
      repeat (8) begin
        queue_command(OP_SELECT, rand_fitness(), rand_fraction());
        added++;
      end
    end
    while (added < n) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        queue_command(OP_UNUSED, rand_fitness(), rand_fraction());
        added++;
      end else begin
        // an append here extends whatever set is current
        queue_command((roll == 1) ? OP_APPEND : OP_START, rand_fitness(), rand_fraction());
        len = $urandom_range(2, 30);
        repeat (len) begin
          roll = $urandom_range(0, 19);
          code = (roll < 11) ? OP_APPEND : (roll < 19) ? OP_SELECT : OP_UNUSED;
          queue_command(code, rand_fitness(), rand_fraction());
        end
        added += len + 1;
      end
    end
  endtask

  // Driver: record accepted beats, present the next one or idle
  always @(posedge clk) begin : driver
    command_t next_cmd;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_picks.insert(expected_picks.size(),
                              predict_pick(op, fitness, random_fraction));
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_cmd = pending_cmds.pop_front();
          start <= 1'b1;
          op <= next_cmd.code;
          fitness <= next_cmd.fit;
          random_fraction <= next_cmd.frac;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin : monitor
    pick_t want;
    if (!rst && done) begin
      if (expected_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat: index %0d status %0d",
                                  chosen_index, status));
      end else begin
        want = expected_picks.pop_front();
        if (chosen_index !== want.index)
          report_mismatch($sformatf("chosen_index %0d, expected %0d",
                                    chosen_index, want.index));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("roulette_wheel_selector verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      // receiver stalls are impossible here, so phase 2 runs without idling
      case (phase)
        1: sender_idle_pct = 64;
        3: sender_idle_pct = 38;
        default: sender_idle_pct = 0;
      endcase
      if (phase == 0) begin
        // empty set, then an append acting as the first member
        queue_command(OP_SELECT, $urandom, '0);
        queue_command(OP_SELECT, $urandom, FRAC_ONE);
        queue_command(OP_UNUSED, $urandom, FRAC_W'($urandom));
        queue_command(OP_APPEND, 32'h0001_0000, FRAC_W'($urandom));
        queue_command(OP_APPEND, 32'h0003_0000, FRAC_W'($urandom));
        // exact boundary between the two members, and fractions at and above one
        queue_command(OP_SELECT, $urandom, '0);
        queue_command(OP_SELECT, $urandom, 17'd16384);
        queue_command(OP_SELECT, $urandom, 17'd16385);
        queue_command(OP_SELECT, $urandom, FRAC_ONE);
        queue_command(OP_SELECT, $urandom, '1);
        queue_command(OP_UNUSED, $urandom, FRAC_W'($urandom));
        // zero total
        queue_command(OP_START, '0, FRAC_W'($urandom));
        queue_command(OP_APPEND, '0, FRAC_W'($urandom));
        queue_command(OP_SELECT, $urandom, FRAC_ONE);
        // widest fitness values
        queue_command(OP_START, '1, FRAC_W'($urandom));
        repeat (3) queue_command(OP_APPEND, '1, FRAC_W'($urandom));
        queue_command(OP_SELECT, $urandom, '0);
        queue_command(OP_SELECT, $urandom, 17'd32768);
        queue_command(OP_SELECT, $urandom, FRAC_ONE);
        queue_command(OP_SELECT, $urandom, '1);
        // zero-weight last member
        queue_command(OP_APPEND, '0, FRAC_W'($urandom));
        queue_command(OP_SELECT, $urandom, FRAC_ONE);
        queue_command(OP_SELECT, $urandom, '1);
      end
      add_random((phase == 0) ? 265 : 290, (phase == 0) || (phase == 3));
      while (pending_cmds.size() != 0 || start || expected_picks.size() != 0)
        @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("roulette_wheel_selector verification clean");
    else
      $display("roulette_wheel_selector verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rws_pkg.sv
hw/rtl/rws_ram.sv
hw/rtl/rws_search.sv
hw/rtl/roulette_wheel_selector.sv
hw/rtl/rws_checker.sv
tb/sv/tb_roulette_wheel_selector.sv
